### design/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

  localparam int CP_W          = 21;
  localparam int BYTE_W        = 8;
  localparam int QUEUE_DEPTH   = 4;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            err;
  } u8d_res_t;

  typedef struct packed {
    u8d_res_t res0;
    u8d_res_t res1;
    logic     two;
  } u8d_entry_t;

endpackage

`default_nettype wire

### design/u8d_if.sv
// ----------------------------------------------------------------------------
// u8d_if
// Valid/ready channels of the decoder: byte stream in, code points out.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8d_in_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::BYTE_W-1:0] in_byte;
  logic                      end_of_string;

  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface u8d_out_if;
  logic                     valid;
  logic                     ready;
  logic [u8d_pkg::CP_W-1:0] code_point;
  logic                     is_error;
  logic                     last_of_run;

  modport source (output valid, code_point, is_error, last_of_run, input ready);
  modport sink   (input valid, code_point, is_error, last_of_run, output ready);
endinterface

`default_nettype wire

### design/utf8_codepoint_decoder.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder
// UTF-8 byte stream to code point decoder.
//
// stream: one byte per request, end_of_string set on the last byte of a
// string. result: one code point or error per request, last_of_run set on
// the final result that a byte causes (a byte causes zero, one or two).
// A byte is taken in every cycle while the result queue has room; a result
// passes through the registered queue before it appears. A byte with two
// results holds the output side for two requests, so the sustained rate is
// one byte per cycle, lower when the receiver stalls or such bytes fill the queue.
// The queue holds QUEUE_DEPTH entries; when the receiver stalls, stream
// ready drops once the queue is full and rises again after the next pop.
// Reset clears the pending sequence and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_decoder #(
  parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  u8d_in_if.sink    stream,
  u8d_out_if.source result
);

  logic                push, full, pop, nonempty;
  u8d_pkg::u8d_entry_t wr_entry, head;

  u8d_front u_front (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .full   (full),
    .push   (push),
    .entry  (wr_entry)
  );

  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .rd_entry (head)
  );

  u8d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .result   (result)
  );

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.is_error |-> result.code_point == '0)
    else $error("error result with nonzero code point");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.last_of_run |=> result.valid)
    else $error("second result of a byte missing");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

### design/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front
// Takes one byte per cycle while the queue is not full, tracks the pending
// sequence and builds the zero, one or two results that the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_front (
  input  wire logic              clk,
  input  wire logic              rst,
  u8d_in_if.sink                 stream,
  input  wire logic              full,
  output logic                   push,
  output u8d_pkg::u8d_entry_t    entry
);

  logic [1:0]                 bytes_pending, bytes_pending_next;
  logic [u8d_pkg::CP_W-1:0]   partial_point, partial_point_next;

  logic                       lead_emit;
  u8d_pkg::u8d_res_t          lead_res;
  logic [1:0]                 lead_pend;
  logic [u8d_pkg::CP_W-1:0]   lead_pp;

  logic [1:0]                 n;
  u8d_pkg::u8d_res_t          res0, res1;
  logic                       accept;

  logic [u8d_pkg::BYTE_W-1:0] c;

  assign c            = stream.in_byte;
  assign stream.ready = !full;
  assign accept       = stream.valid && stream.ready;

  // lead byte classification
  always_comb begin
    lead_emit = 1'b0;
    lead_res  = '0;
    lead_pend = 2'd0;
    lead_pp   = '0;
    if (!c[7]) begin
      lead_emit   = 1'b1;
      lead_res.cp = {{(u8d_pkg::CP_W-8){1'b0}}, c};
    end else if (c[7:5] == 3'b110) begin
      lead_pend = 2'd1;
      lead_pp   = {{(u8d_pkg::CP_W-5){1'b0}}, c[4:0]};
    end else if (c[7:4] == 4'b1110) begin
      lead_pend = 2'd2;
      lead_pp   = {{(u8d_pkg::CP_W-4){1'b0}}, c[3:0]};
    end else if (c[7:3] == 5'b11110) begin
      lead_pend = 2'd3;
      lead_pp   = {{(u8d_pkg::CP_W-3){1'b0}}, c[2:0]};
    end else begin
      lead_emit    = 1'b1;
      lead_res.err = 1'b1;
    end
  end

  always_comb begin
    n                  = 2'd0;
    res0               = '0;
    res1               = '0;
    bytes_pending_next = bytes_pending;
    partial_point_next = partial_point;
    if (bytes_pending != 2'd0) begin
      if (c[7:6] == 2'b10) begin
        partial_point_next = {partial_point[u8d_pkg::CP_W-7:0], c[5:0]};
        bytes_pending_next = bytes_pending - 2'd1;
        if (bytes_pending_next == 2'd0) begin
          res0.cp            = partial_point_next;
          n                  = 2'd1;
          partial_point_next = '0;
        end
      end else begin
        // bad continuation, then the byte is taken as a lead
        res0.err           = 1'b1;
        n                  = 2'd1;
        bytes_pending_next = lead_pend;
        partial_point_next = lead_pp;
        if (lead_emit) begin
          res1 = lead_res;
          n    = 2'd2;
        end
      end
    end else begin
      bytes_pending_next = lead_pend;
      partial_point_next = lead_pp;
      if (lead_emit) begin
        res0 = lead_res;
        n    = 2'd1;
      end
    end
    // truncated sequence
    if (stream.end_of_string && bytes_pending_next != 2'd0) begin
      if (n == 2'd0) begin
        res0.err = 1'b1;
      end else begin
        res1.err = 1'b1;
      end
      n                  = n + 2'd1;
      bytes_pending_next = 2'd0;
      partial_point_next = '0;
    end
  end

  assign push       = accept && (n != 2'd0);
  assign entry.res0 = res0;
  assign entry.res1 = res1;
  assign entry.two  = n[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      partial_point <= '0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      partial_point <= partial_point_next;
    end
  end

endmodule

`default_nettype wire

### design/u8d_queue.sv
// ----------------------------------------------------------------------------
// u8d_queue
// Short queue of result entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_queue #(
  parameter int DEPTH = u8d_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire u8d_pkg::u8d_entry_t wr_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     nonempty,
  output u8d_pkg::u8d_entry_t      rd_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8d_pkg::u8d_entry_t mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0]    count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### design/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back
// Sends the results of the head entry, one per request, and marks the
// last result of each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                nonempty,
  input  wire u8d_pkg::u8d_entry_t head,
  output logic                     pop,
  u8d_out_if.source                result
);

  logic              phase;
  u8d_pkg::u8d_res_t cur;
  logic              fire;

  assign cur                = phase ? head.res1 : head.res0;
  assign result.valid       = nonempty;
  assign result.code_point  = cur.cp;
  assign result.is_error    = cur.err;
  assign result.last_of_run = phase || !head.two;

  assign fire = result.valid && result.ready;
  assign pop  = fire && (phase || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (fire) begin
      phase <= head.two && !phase;
    end
  end

endmodule

`default_nettype wire

### verif/tb_utf8_codepoint_decoder.sv
// ----------------------------------------------------------------------------
// tb_utf8_codepoint_decoder
// Drives UTF-8 byte strings into the decoder with random gaps and result
// stalls. A scoreboard decodes each accepted byte on its own and checks every
// code point or error result, in order, against what it predicted.
// ----------------------------------------------------------------------------
module tb_utf8_codepoint_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CP_W        = u8d_pkg::CP_W;
  localparam int         ITEMS       = 750;
  localparam int         CALM_TAIL   = 120;
  localparam int         MAX_REPORTS = 10;
  localparam logic [1:0] CONT_TAG    = 2'b10;
  localparam logic [2:0] LEAD2_TAG   = 3'b110;
  localparam logic [3:0] LEAD3_TAG   = 4'b1110;
  localparam logic [4:0] LEAD4_TAG   = 5'b11110;

  // bit 8 marks the end of a string
  localparam logic [8:0] DIRECTED [25] = '{
    9'h000, 9'h17F,
    9'h0C2, 9'h1A9,
    9'h0E2, 9'h082, 9'h0AC,
    9'h0F0, 9'h09F, 9'h098, 9'h080,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h080, 9'h0FF,
    9'h0C3, 9'h041,
    9'h0E1, 9'h080, 9'h0FF,
    9'h1C2,
    9'h0C2, 9'h1F0
  };

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            err;
    logic            tail;
  } cp_result_t;

  class codepoint_scoreboard;
    logic [1:0]      cont_due;
    logic [CP_W-1:0] partial_cp;
    cp_result_t      due_points[$];
    int              mismatches;
    int              bytes_seen;
    int              results_seen;
    int              errors_seen;
    int              pair_bytes;

    function new();
      cont_due     = '0;
      partial_cp   = '0;
      mismatches   = 0;
      bytes_seen   = 0;
      results_seen = 0;
      errors_seen  = 0;
      pair_bytes   = 0;
    endfunction

    function cp_result_t make_res(logic [CP_W-1:0] cp, logic err);
      cp_result_t r;
      r.cp   = cp;
      r.err  = err;
      r.tail = 1'b0;
      return r;
    endfunction

    function bit decode_lead(logic [7:0] c, output cp_result_t r);
      r = make_res('0, 1'b1);
      if (c[7] == 1'b0) begin
        r = make_res(CP_W'(c), 1'b0);
        return 1'b1;
      end
      if (c[7:5] == LEAD2_TAG) begin
        partial_cp = CP_W'(c[4:0]);
        cont_due   = 2'd1;
        return 1'b0;
      end
      if (c[7:4] == LEAD3_TAG) begin
        partial_cp = CP_W'(c[3:0]);
        cont_due   = 2'd2;
        return 1'b0;
      end
      if (c[7:3] == LEAD4_TAG) begin
        partial_cp = CP_W'(c[2:0]);
        cont_due   = 2'd3;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] c, logic eos);
      cp_result_t res[$];
      cp_result_t r;
      bytes_seen++;
      if (cont_due != 0) begin
        if (c[7:6] == CONT_TAG) begin
          partial_cp = {partial_cp[CP_W-7:0], c[5:0]};
          cont_due   = cont_due - 2'd1;
          if (cont_due == 0) begin
            res        = {res, make_res(partial_cp, 1'b0)};
            partial_cp = '0;
          end
        end else begin
          // broken sequence, then the byte starts over as a lead
          res        = {res, make_res('0, 1'b1)};
          cont_due   = '0;
          partial_cp = '0;
          if (decode_lead(c, r)) res = {res, r};
        end
      end else if (decode_lead(c, r)) begin
        res = {res, r};
      end
      if (eos && cont_due != 0) begin
        res        = {res, make_res('0, 1'b1)};
        cont_due   = '0;
        partial_cp = '0;
      end
      if (res.size() > 0) res[res.size()-1].tail = 1'b1;
      if (res.size() == 2) pair_bytes++;
      foreach (res[i]) due_points = {due_points, res[i]};
    endfunction

    function void check_result(logic [CP_W-1:0] cp, logic err, logic tail);
      cp_result_t got;
      cp_result_t want;
      got.cp   = cp;
      got.err  = err;
      got.tail = tail;
      results_seen++;
      if (err) errors_seen++;
      if (due_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none due: cp=%h err=%b last=%b", $realtime, cp, err,
                   tail);
      end else begin
        want = due_points.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result %0d expected cp=%h err=%b last=%b, got cp=%h err=%b last=%b",
                     $realtime, results_seen, want.cp, want.err, want.tail, cp, err, tail);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   calm;
  int   sent;

  codepoint_scoreboard sb;

  u8d_in_if  stream_if ();
  u8d_out_if result_if ();

  utf8_codepoint_decoder DUT (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  always begin
    #10ns clk = 1'b1;
    #10ns clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (stream_if.valid && stream_if.ready)
        sb.note_byte(stream_if.in_byte, stream_if.end_of_string);
      if (result_if.valid && result_if.ready)
        sb.check_result(result_if.code_point, result_if.is_error, result_if.last_of_run);
    end
  end

  initial begin
    result_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    stream_if.valid         <= 1'b1;
    stream_if.in_byte       <= b;
    stream_if.end_of_string <= eos;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      stream_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    stream_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_points.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_run();
    logic [7:0] seq[$];
    logic [7:0] b;
    int         kind;
    int         len;
    int         cut;
    bit         tail_eos;
    kind     = $urandom_range(0, 9);
    len      = $urandom_range(2, 4);
    tail_eos = ($urandom_range(0, 5) == 0);
    case (kind)
      0, 1: begin
        seq = {seq, 8'($urandom_range(0, 127))};
      end
      7: begin
        seq = {seq, 8'($urandom)};
      end
      default: begin
        case (len)
          2:       b = {LEAD2_TAG, 5'($urandom)};
          3:       b = {LEAD3_TAG, 4'($urandom)};
          default: b = {LEAD4_TAG, 3'($urandom)};
        endcase
        seq = {seq, b};
        for (int i = 1; i < len; i++) begin
          b   = {CONT_TAG, 6'($urandom)};
          seq = {seq, b};
        end
        if (kind >= 8) begin
          cut = $urandom_range(1, len - 1);
          while (seq.size() > cut) void'(seq.pop_back());
        end
        if (kind == 8) begin
          b = 8'($urandom);
          if (b[7:6] == CONT_TAG) b[6] = 1'b1;
          seq = {seq, b};
        end
        if (kind == 9) tail_eos = 1'b1;
      end
    endcase
    foreach (seq[i]) send_byte(seq[i], (i == seq.size() - 1) ? tail_eos : 1'b0);
  endtask

  initial begin
    bit mid_pause_done;
    mid_pause_done          = 1'b0;
    calm                    = 1'b0;
    sent                    = 0;
    sb                      = new();
    rst                     <= 1'b1;
    stream_if.valid         <= 1'b0;
    stream_if.in_byte       <= '0;
    stream_if.end_of_string <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_drained();

    while (sent < ITEMS) begin
      if (sent >= ITEMS - CALM_TAIL) calm = 1'b1;
      if (!mid_pause_done && sent >= ITEMS / 2) begin
        wait_drained();
        mid_pause_done = 1'b1;
      end
      send_random_run();
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("decoded %0d bytes into %0d results: %0d errors, %0d bytes with two results",
             sb.bytes_seen, sb.results_seen, sb.errors_seen, sb.pair_bytes);
    $display("%0d mismatches, %0d results left due", sb.mismatches, sb.due_points.size());
    if (sb.mismatches == 0 && sb.due_points.size() == 0) begin
      $display("utf8_codepoint_decoder verification clean");
    end else begin
      $display("utf8_codepoint_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("utf8_codepoint_decoder verification failed");
    $finish;
  end

endmodule
